/* rtl/ukf_pkg.sv */
// Shared constants and codes for the unique key queue.
package ukf_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

endpackage

/* rtl/unique_key_fifo.sv */
// Top level of the unique key queue: control sequencer and key and data memories.
//
// A bounded first-in first-out queue of key and data pairs with unique keys,
// held in two single-port synchronous memories with registered read outputs.
// A request is taken only while the sequencer is idle, one at a time. An enqueue
// reads every held key from the key memory, one per cycle, and then writes the
// pair unless a key matched or the queue is full. A dequeue reads the head and
// goes via S_DEQ_RD to S_RESULT; an underflow skips S_DEQ_RD. The result sits in an
// output register, so the next request is taken while a result waits; a result
// that cannot be handed on holds the sequencer until the output register frees.
// There is no clearing pass: entries are read only after they are written.
module unique_key_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [ukf_pkg::WORD_W-1:0]   in_key,
	input  logic signed [ukf_pkg::WORD_W-1:0]   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [ukf_pkg::STATUS_W-1:0] status,
	output logic signed [ukf_pkg::WORD_W-1:0]   out_key,
	output logic signed [ukf_pkg::WORD_W-1:0]   out_data,
	output logic        [ukf_pkg::OCC_W-1:0]    occupancy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_DEQ_RD = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	localparam logic [ukf_pkg::IDX_W-1:0] LAST_IDX = ukf_pkg::IDX_W'(ukf_pkg::DEPTH - 1);
	localparam logic [ukf_pkg::CNT_W-1:0] FULL_CNT = ukf_pkg::CNT_W'(ukf_pkg::DEPTH);

	logic [ukf_pkg::WORD_W-1:0] key_mem [ukf_pkg::DEPTH];
	logic [ukf_pkg::WORD_W-1:0] data_mem [ukf_pkg::DEPTH];

	logic [1:0]                    state_q;
	logic [ukf_pkg::IDX_W-1:0]     head_q;
	logic [ukf_pkg::IDX_W-1:0]     tail_q;
	logic [ukf_pkg::CNT_W-1:0]     count_q;
	logic [ukf_pkg::IDX_W-1:0]     ptr_q;
	logic [ukf_pkg::CNT_W-1:0]     iss_q;
	logic                          hit_q;
	logic                          rd_vld_s1;
	logic [ukf_pkg::WORD_W-1:0]    key_rd_s1;
	logic [ukf_pkg::WORD_W-1:0]    data_rd_s1;
	logic [ukf_pkg::WORD_W-1:0]    req_key_q;
	logic [ukf_pkg::WORD_W-1:0]    req_data_q;
	logic [ukf_pkg::STATUS_W-1:0]  res_status_q;
	logic [ukf_pkg::WORD_W-1:0]    res_key_q;
	logic [ukf_pkg::WORD_W-1:0]    res_data_q;
	logic [ukf_pkg::CNT_W-1:0]     res_count_q;
	logic                          out_valid_q;
	logic [ukf_pkg::STATUS_W-1:0]  out_status_q;
	logic [ukf_pkg::WORD_W-1:0]    out_key_q;
	logic [ukf_pkg::WORD_W-1:0]    out_data_q;
	logic [ukf_pkg::CNT_W-1:0]     out_count_q;

	logic                          accept;
	logic                          rd_en;
	logic [ukf_pkg::IDX_W-1:0]     rd_addr;
	logic                          wr_en;
	logic                          search_done;
	logic                          out_free;

	function automatic logic [ukf_pkg::IDX_W-1:0] advance(input logic [ukf_pkg::IDX_W-1:0] i);
		advance = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	assign accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign search_done = (state_q == S_SEARCH) && (iss_q >= count_q) && !rd_vld_s1;
	assign wr_en = search_done && !hit_q && (count_q < FULL_CNT);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = ptr_q;
		if (accept && (func == ukf_pkg::FUNC_DEQ)) begin
			rd_en = (count_q != '0);
			rd_addr = head_q;
		end else if ((state_q == S_SEARCH) && (iss_q < count_q)) begin
			rd_en = 1'b1;
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[tail_q] <= req_key_q;
			data_mem[tail_q] <= req_data_q;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[rd_addr];
			data_rd_s1 <= data_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q <= in_key;
			req_data_q <= in_data;
		end
		if (accept && (func == ukf_pkg::FUNC_DEQ) && (count_q == '0)) begin
			res_status_q <= ukf_pkg::ST_UNDER;
			res_key_q <= '0;
			res_data_q <= '0;
			res_count_q <= count_q;
		end
		if (search_done) begin
			res_key_q <= '0;
			res_data_q <= '0;
			if (hit_q) begin
				res_status_q <= ukf_pkg::ST_DUP;
				res_count_q <= count_q;
			end else if (count_q >= FULL_CNT) begin
				res_status_q <= ukf_pkg::ST_FULL;
				res_count_q <= count_q;
			end else begin
				res_status_q <= ukf_pkg::ST_OK;
				res_count_q <= count_q + 1'b1;
			end
		end
		if (state_q == S_DEQ_RD) begin
			res_status_q <= ukf_pkg::ST_OK;
			res_key_q <= key_rd_s1;
			res_data_q <= data_rd_s1;
			res_count_q <= count_q - 1'b1;
		end
		if ((state_q == S_RESULT) && out_free) begin
			out_status_q <= res_status_q;
			out_key_q <= res_key_q;
			out_data_q <= res_data_q;
			out_count_q <= res_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			ptr_q <= '0;
			iss_q <= '0;
			hit_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en && (state_q == S_SEARCH);
			if (rd_vld_s1 && (key_rd_s1 == req_key_q)) begin
				hit_q <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == ukf_pkg::FUNC_DEQ) begin
							state_q <= (count_q == '0) ? S_RESULT : S_DEQ_RD;
						end else begin
							ptr_q <= head_q;
							iss_q <= '0;
							hit_q <= 1'b0;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (iss_q < count_q) begin
						ptr_q <= advance(ptr_q);
						iss_q <= iss_q + 1'b1;
					end else if (!rd_vld_s1) begin
						if (wr_en) begin
							tail_q <= advance(tail_q);
							count_q <= count_q + 1'b1;
						end
						state_q <= S_RESULT;
					end
				end
				S_DEQ_RD: begin
					head_q <= advance(head_q);
					count_q <= count_q - 1'b1;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign out_key = out_key_q;
	assign out_data = out_data_q;
	assign occupancy = ukf_pkg::OCC_W'(out_count_q);

endmodule
